// ----- design/sedp_pkg.sv -----
`default_nettype none

package sedp_pkg;

    localparam int ByteW  = 8;
    localparam int IndexW = 16;
    localparam int KindW  = 2;
    localparam int CfgIdxW = 3;

    typedef logic [KindW-1:0] kind_t;

    localparam kind_t KIND_NONE  = 2'd0;
    localparam kind_t KIND_VALUE = 2'd1;
    localparam kind_t KIND_ERROR = 2'd2;
    localparam kind_t KIND_END   = 2'd3;

    typedef logic [CfgIdxW-1:0] cfg_index_t;

    localparam cfg_index_t CFG_FORMAT_CODE    = 3'd0;
    localparam cfg_index_t CFG_TAG_INDEX_HIGH = 3'd1;
    localparam cfg_index_t CFG_TAG_INDEX_LOW  = 3'd2;
    localparam cfg_index_t CFG_TAG_VALID_DATA = 3'd3;
    localparam cfg_index_t CFG_TAG_NULL_DATA  = 3'd4;
    localparam cfg_index_t CFG_TAG_END        = 3'd5;

    localparam logic [ByteW-1:0] RST_FORMAT_CODE    = 8'd10;
    localparam logic [ByteW-1:0] RST_TAG_INDEX_HIGH = 8'd170;
    localparam logic [ByteW-1:0] RST_TAG_INDEX_LOW  = 8'd165;
    localparam logic [ByteW-1:0] RST_TAG_VALID_DATA = 8'd90;
    localparam logic [ByteW-1:0] RST_TAG_NULL_DATA  = 8'd85;
    localparam logic [ByteW-1:0] RST_TAG_END        = 8'd7;

    typedef enum logic [4:0] {
        PH_FORMAT = 5'b00001,
        PH_TAG    = 5'b00010,
        PH_DATA   = 5'b00100,
        PH_IGNORE = 5'b01000,
        PH_ERROR  = 5'b10000
    } phase_t;

endpackage

`default_nettype wire

// ----- design/sedp_byte_if.sv -----
`default_nettype none

interface sedp_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       line_start;

    modport source (output valid, output byte_in, output line_start, input ready);
    modport sink   (input valid, input byte_in, input line_start, output ready);

endinterface

`default_nettype wire

// ----- design/sedp_result_if.sv -----
`default_nettype none

interface sedp_result_if;

    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] reg_index;
    logic [7:0]  reg_value;

    modport source (output valid, output kind, output reg_index, output reg_value, input ready);
    modport sink   (input valid, input kind, input reg_index, input reg_value, output ready);

endinterface

`default_nettype wire

// ----- design/sensor_embedded_data_parser_unit.sv -----
`default_nettype none

// Channel   Dir  Beat fields                      Width
// din       in   byte_in, line_start              8, 1
// dout      out  kind, reg_index, reg_value       2, 16, 8
// cfg       in   cfg_we, cfg_index, cfg_data      1, 3, 8
//
// One byte per clock while result beats drain: every accepted byte yields one result beat on the next cycle.
// Parser state and the result register update in the same edge that takes the byte.
// din.ready drops only while a result is held and dout.ready is low.
// Reset restores the tag registers to their defaults and expects a format byte.

module sensor_embedded_data_parser_unit (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    sedp_byte_if.sink                     din,
    sedp_result_if.source                 dout,
    input  wire logic                     cfg_we,
    input  wire sedp_pkg::cfg_index_t     cfg_index,
    input  wire logic [sedp_pkg::ByteW-1:0] cfg_data
);
    import sedp_pkg::*;

    logic [ByteW-1:0] format_code_reg;
    logic [ByteW-1:0] tag_hi_reg;
    logic [ByteW-1:0] tag_lo_reg;
    logic [ByteW-1:0] tag_valid_reg;
    logic [ByteW-1:0] tag_null_reg;
    logic [ByteW-1:0] tag_end_reg;

    phase_t            phase_reg, phase_next;
    logic [ByteW-1:0]  held_tag_reg, held_tag_next;
    logic [IndexW-1:0] index_reg, index_next;
    logic              high_seen_reg, high_seen_next;
    logic              low_seen_reg, low_seen_next;

    logic              out_valid_reg;
    kind_t             kind_reg, kind_next;
    logic [IndexW-1:0] rindex_reg, rindex_next;
    logic [ByteW-1:0]  rvalue_reg, rvalue_next;

    phase_t            ph;
    logic [ByteW-1:0]  held;
    logic [IndexW-1:0] idx;
    logic              hs, ls;
    logic [ByteW-1:0]  b;
    logic              accept;

    assign din.ready = !out_valid_reg || dout.ready;
    assign accept    = din.valid && din.ready;

    assign dout.valid     = out_valid_reg;
    assign dout.kind      = kind_reg;
    assign dout.reg_index = rindex_reg;
    assign dout.reg_value = rvalue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_code_reg <= RST_FORMAT_CODE;
            tag_hi_reg      <= RST_TAG_INDEX_HIGH;
            tag_lo_reg      <= RST_TAG_INDEX_LOW;
            tag_valid_reg   <= RST_TAG_VALID_DATA;
            tag_null_reg    <= RST_TAG_NULL_DATA;
            tag_end_reg     <= RST_TAG_END;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FORMAT_CODE:    format_code_reg <= cfg_data;
                CFG_TAG_INDEX_HIGH: tag_hi_reg      <= cfg_data;
                CFG_TAG_INDEX_LOW:  tag_lo_reg      <= cfg_data;
                CFG_TAG_VALID_DATA: tag_valid_reg   <= cfg_data;
                CFG_TAG_NULL_DATA:  tag_null_reg    <= cfg_data;
                CFG_TAG_END:        tag_end_reg     <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        b    = din.byte_in;
        // line start clears the line state before this byte is decoded
        ph   = din.line_start ? PH_FORMAT : phase_reg;
        held = din.line_start ? '0 : held_tag_reg;
        idx  = din.line_start ? '0 : index_reg;
        hs   = din.line_start ? 1'b0 : high_seen_reg;
        ls   = din.line_start ? 1'b0 : low_seen_reg;

        phase_next     = ph;
        held_tag_next  = held;
        index_next     = idx;
        high_seen_next = hs;
        low_seen_next  = ls;
        kind_next      = KIND_NONE;
        rindex_next    = '0;
        rvalue_next    = '0;

        unique case (ph)
            PH_FORMAT:
            begin
                phase_next = (b == format_code_reg) ? PH_TAG : PH_IGNORE;
            end
            PH_TAG:
            begin
                if (b == tag_end_reg)
                begin
                    kind_next = KIND_END;
                end
                else if (b == tag_hi_reg || (b == tag_lo_reg && hs) ||
                         ((b == tag_valid_reg || b == tag_null_reg) && hs && ls))
                begin
                    held_tag_next = b;
                    phase_next    = PH_DATA;
                end
                else
                begin
                    phase_next = PH_ERROR;
                    kind_next  = KIND_ERROR;
                end
            end
            PH_DATA:
            begin
                phase_next = PH_TAG;
                // held tag is matched against the registers as they are now
                if (held == tag_hi_reg)
                begin
                    index_next     = {b, {ByteW{1'b0}}};
                    high_seen_next = 1'b1;
                    low_seen_next  = 1'b0;
                end
                else if (held == tag_lo_reg)
                begin
                    index_next    = {idx[IndexW-1:ByteW], b};
                    low_seen_next = 1'b1;
                end
                else if (held == tag_valid_reg)
                begin
                    kind_next   = KIND_VALUE;
                    rindex_next = idx;
                    rvalue_next = b;
                    index_next  = idx + 16'd1;
                end
                else if (held == tag_null_reg)
                begin
                    index_next = idx + 16'd1;
                end
                else
                begin
                    phase_next = PH_ERROR;
                    kind_next  = KIND_ERROR;
                end
            end
            PH_ERROR:
            begin
                kind_next = KIND_ERROR;
            end
            PH_IGNORE:
            begin
                phase_next = PH_IGNORE;
            end
            default:
            begin
                phase_next = PH_IGNORE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FORMAT;
            held_tag_reg  <= '0;
            index_reg     <= '0;
            high_seen_reg <= 1'b0;
            low_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                held_tag_reg  <= held_tag_next;
                index_reg     <= index_next;
                high_seen_reg <= high_seen_next;
                low_seen_reg  <= low_seen_next;
                out_valid_reg <= 1'b1;
            end
            else if (dout.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= kind_next;
            rindex_reg <= rindex_next;
            rvalue_reg <= rvalue_next;
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import sedp_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 300;

    // indexes past the register list; writes there must be ignored
    localparam cfg_index_t CFG_SPARE_A = 3'd6;
    localparam cfg_index_t CFG_SPARE_B = 3'd7;

    typedef enum int {
        SET_DEFAULT,
        SET_LOW_EXTREME,
        SET_HIGH_EXTREME,
        SET_CLASHING,
        SET_RANDOM,
        SET_COUNT
    } tag_set_t;

    typedef struct packed {
        kind_t                  kind;
        logic [IndexW-1:0]      reg_index;
        logic [ByteW-1:0]       reg_value;
    } parse_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_index_t cfg_index;
    logic [ByteW-1:0] cfg_data;

    sedp_byte_if   byte_ch ();
    sedp_result_if result_ch ();

    sensor_embedded_data_parser_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (byte_ch),
        .dout      (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // parser copy: tag registers
    logic [ByteW-1:0] fmt_code     = RST_FORMAT_CODE;
    logic [ByteW-1:0] tag_hi       = RST_TAG_INDEX_HIGH;
    logic [ByteW-1:0] tag_lo       = RST_TAG_INDEX_LOW;
    logic [ByteW-1:0] tag_val      = RST_TAG_VALID_DATA;
    logic [ByteW-1:0] tag_nul      = RST_TAG_NULL_DATA;
    logic [ByteW-1:0] tag_end_code = RST_TAG_END;

    // parser copy: line state
    phase_t            line_phase = PH_FORMAT;
    logic [ByteW-1:0]  held_tag   = '0;
    logic [IndexW-1:0] cur_index  = '0;
    logic              hi_loaded  = 1'b0;
    logic              lo_loaded  = 1'b0;

    parse_result_t pending_parse_results[$];

    int check_failures = 0;
    int bytes_sent = 0;
    int lines_started = 0;
    int kind_seen[4] = '{0, 0, 0, 0};
    int idle_cycles = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_off_left = 0;

    always #10 clk = ~clk;

    function automatic parse_result_t decode_embedded_byte(logic [ByteW-1:0] b, logic ls);
        parse_result_t r;
        logic          full;
        r = '{KIND_NONE, '0, '0};
        full = hi_loaded && lo_loaded;
        if (ls)
        begin
            line_phase = PH_FORMAT;
            held_tag = '0;
            cur_index = '0;
            hi_loaded = 1'b0;
            lo_loaded = 1'b0;
        end
        case (line_phase)
            PH_FORMAT:
                line_phase = (b == fmt_code) ? PH_TAG : PH_IGNORE;
            PH_TAG:
            begin
                // end tag wins over every other match
                if (b == tag_end_code)
                    r.kind = KIND_END;
                else if (b == tag_hi || (b == tag_lo && hi_loaded) ||
                         ((b == tag_val || b == tag_nul) && full))
                begin
                    held_tag = b;
                    line_phase = PH_DATA;
                end
                else
                begin
                    line_phase = PH_ERROR;
                    r.kind = KIND_ERROR;
                end
            end
            PH_DATA:
            begin
                // held tag is decoded against the registers as they are now
                line_phase = PH_TAG;
                if (held_tag == tag_hi)
                begin
                    cur_index = {b, 8'h00};
                    hi_loaded = 1'b1;
                    lo_loaded = 1'b0;
                end
                else if (held_tag == tag_lo)
                begin
                    cur_index[7:0] = b;
                    lo_loaded = 1'b1;
                end
                else if (held_tag == tag_val)
                begin
                    r = '{KIND_VALUE, cur_index, b};
                    cur_index = cur_index + 1'b1;
                end
                else if (held_tag == tag_nul)
                    cur_index = cur_index + 1'b1;
                else
                begin
                    line_phase = PH_ERROR;
                    r.kind = KIND_ERROR;
                end
            end
            PH_ERROR:
                r.kind = KIND_ERROR;
            default:
                line_phase = PH_IGNORE;
        endcase
        return r;
    endfunction

    // result checking, prediction on accepted bytes, register tracking, watchdog
    always @(posedge clk)
    begin
        parse_result_t want;
        parse_result_t got;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got = '{result_ch.kind, result_ch.reg_index, result_ch.reg_value};
                if (pending_parse_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat: expected none, actual kind %0d index %h value %h",
                             $time, got.kind, got.reg_index, got.reg_value);
                    check_failures++;
                end
                else
                begin
                    want = pending_parse_results.pop_front();
                    if (got.kind !== want.kind)
                    begin
                        $display("%0t: kind mismatch: expected %0d, actual %0d",
                                 $time, want.kind, got.kind);
                        check_failures++;
                    end
                    if (got.reg_index !== want.reg_index)
                    begin
                        $display("%0t: reg_index mismatch: expected %h, actual %h",
                                 $time, want.reg_index, got.reg_index);
                        check_failures++;
                    end
                    if (got.reg_value !== want.reg_value)
                    begin
                        $display("%0t: reg_value mismatch: expected %h, actual %h",
                                 $time, want.reg_value, got.reg_value);
                        check_failures++;
                    end
                    kind_seen[want.kind]++;
                end
            end
            if (byte_ch.valid && byte_ch.ready)
            begin
                pending_parse_results.push_back(
                    decode_embedded_byte(byte_ch.byte_in, byte_ch.line_start));
                bytes_sent++;
                if (byte_ch.line_start)
                    lines_started++;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FORMAT_CODE:    fmt_code = cfg_data;
                    CFG_TAG_INDEX_HIGH: tag_hi = cfg_data;
                    CFG_TAG_INDEX_LOW:  tag_lo = cfg_data;
                    CFG_TAG_VALID_DATA: tag_val = cfg_data;
                    CFG_TAG_NULL_DATA:  tag_nul = cfg_data;
                    CFG_TAG_END:        tag_end_code = cfg_data;
                    default: ;
                endcase
            end
            if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // result side: random stalls, plus a counted hold-off when one is requested
    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end
        else
            result_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    task automatic send_byte(logic [ByteW-1:0] b, logic ls);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            @(negedge clk);
            byte_ch.valid <= 1'b0;
            byte_ch.byte_in <= $urandom_range(0, 255);
            byte_ch.line_start <= $urandom_range(0, 1);
            repeat ($urandom_range(0, 2)) @(negedge clk);
        end
        @(negedge clk);
        byte_ch.valid <= 1'b1;
        byte_ch.byte_in <= b;
        byte_ch.line_start <= ls;
        do
            @(posedge clk);
        while (!byte_ch.ready);
    endtask

    // stop offering bytes and wait for every predicted result
    task automatic quiesce();
        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (pending_parse_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_cfg(cfg_index_t idx, logic [ByteW-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_tags(logic [ByteW-1:0] f, logic [ByteW-1:0] h, logic [ByteW-1:0] l,
                                logic [ByteW-1:0] v, logic [ByteW-1:0] n, logic [ByteW-1:0] e);
        write_cfg(CFG_FORMAT_CODE, f);
        write_cfg(CFG_TAG_INDEX_HIGH, h);
        write_cfg(CFG_TAG_INDEX_LOW, l);
        write_cfg(CFG_TAG_VALID_DATA, v);
        write_cfg(CFG_TAG_NULL_DATA, n);
        write_cfg(CFG_TAG_END, e);
        write_cfg(CFG_SPARE_A, $urandom_range(0, 255));
        write_cfg(CFG_SPARE_B, $urandom_range(0, 255));
    endtask

    task automatic apply_tag_set(tag_set_t s);
        case (s)
            SET_DEFAULT:
                program_tags(RST_FORMAT_CODE, RST_TAG_INDEX_HIGH, RST_TAG_INDEX_LOW,
                             RST_TAG_VALID_DATA, RST_TAG_NULL_DATA, RST_TAG_END);
            SET_LOW_EXTREME:
                program_tags(8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01);
            SET_HIGH_EXTREME:
                program_tags(8'hFF, 8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80);
            // tiny code space: tags collide, decode priority matters
            SET_CLASHING:
                program_tags($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
                             $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
            default:
                program_tags($urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255), $urandom_range(0, 255));
        endcase
    endtask

    function automatic logic [ByteW-1:0] index_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            return 8'hFF;
        else if (pick < 35)
            return 8'h00;
        return $urandom_range(0, 255);
    endfunction

    // mostly well-formed line with random content, salted with noise
    task automatic send_random_line();
        int n_ops;
        int pick;
        n_ops = $urandom_range(2, 14);
        if ($urandom_range(0, 19) != 0)
            send_byte(($urandom_range(0, 9) != 0) ? fmt_code : $urandom_range(0, 255), 1'b1);
        if ($urandom_range(0, 4) != 0)
        begin
            send_byte(tag_hi, 1'b0);
            send_byte(index_byte(), 1'b0);
            send_byte(tag_lo, 1'b0);
            send_byte(index_byte(), 1'b0);
        end
        repeat (n_ops)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                send_byte(tag_hi, 1'b0);
                send_byte(index_byte(), 1'b0);
            end
            else if (pick < 16)
            begin
                send_byte(tag_lo, 1'b0);
                send_byte(index_byte(), 1'b0);
            end
            else if (pick < 58)
            begin
                send_byte(tag_val, 1'b0);
                send_byte($urandom_range(0, 255), 1'b0);
            end
            else if (pick < 76)
            begin
                send_byte(tag_nul, 1'b0);
                send_byte($urandom_range(0, 255), 1'b0);
            end
            else if (pick < 82)
                send_byte(tag_end_code, 1'b0);
            else if (pick < 94)
                send_byte($urandom_range(0, 255), 1'b0);
            else
                send_byte($urandom_range(0, 255), 1'b1);
        end
    endtask

    task automatic test_directed_lines();
        // first line without a line start; index wraps past 0xFFFF
        send_byte(8'h0A, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h07, 1'b0);
        // unknown tag, then the error sticks
        send_byte(8'h33, 1'b0);
        send_byte(8'h5A, 1'b0);
        // index low before index high
        send_byte(8'h0A, 1'b1);
        send_byte(8'hA5, 1'b0);
        // data tag with only the high byte loaded
        send_byte(8'h0A, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h5A, 1'b0);
        // line start while a data byte is due, foreign format ignores the line
        send_byte(8'h0A, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h5A, 1'b0);
        quiesce();
    endtask

    task automatic test_midline_retag();
        send_byte(RST_FORMAT_CODE, 1'b1);
        send_byte(RST_TAG_INDEX_HIGH, 1'b0);
        quiesce();
        // held tag no longer matches when its data byte arrives
        write_cfg(CFG_TAG_INDEX_HIGH, 8'h3C);
        send_byte(8'h12, 1'b0);
        send_byte(8'h3C, 1'b0);
        quiesce();
        apply_tag_set(SET_DEFAULT);
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_pct, int n_items);
        int target;
        tx_idle_pct = idle_pct;
        rx_stall_pct = stall_pct;
        for (int s = 0; s < SET_COUNT; s++)
        begin
            quiesce();
            apply_tag_set(tag_set_t'(s));
            target = bytes_sent + n_items / SET_COUNT;
            while (bytes_sent < target)
                send_random_line();
        end
        quiesce();
    endtask

    task automatic test_backpressure_fill();
        int target;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        apply_tag_set(SET_DEFAULT);
        @(posedge clk);
        hold_off_left = HOLD_OFF_CYCLES;
        target = bytes_sent + 40;
        while (bytes_sent < target)
            send_random_line();
        // sender waits here until every result has drained
        quiesce();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_FORMAT_CODE;
        cfg_data = '0;
        byte_ch.valid = 1'b0;
        byte_ch.byte_in = '0;
        byte_ch.line_start = 1'b0;
        result_ch.ready = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_directed_lines();
        test_midline_retag();
        test_random_traffic(0, 0, 400);
        test_random_traffic(66, 0, 400);
        test_random_traffic(0, 66, 400);
        test_random_traffic(7, 7, 400);
        test_backpressure_fill();

        quiesce();
        repeat (4) @(posedge clk);
        if (pending_parse_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_parse_results.size());
            check_failures++;
        end
        $display("Parsed %0d bytes over %0d line starts under default, extreme, clashing and random tags.",
                 bytes_sent, lines_started);
        $display("Results: %0d register values, %0d errors, %0d end tags, %0d quiet.",
                 kind_seen[KIND_VALUE], kind_seen[KIND_ERROR], kind_seen[KIND_END],
                 kind_seen[KIND_NONE]);
        if (check_failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
